// ===== src/mtd_pkg.sv =====
`timescale 1ns / 1ps

package mtd_pkg;

  localparam int MAX_DURATIONS = 64;
  localparam int TIME_BITS     = 27;
  localparam int MAX_RESULTS   = 64;

  localparam int CNT_W  = $clog2(MAX_DURATIONS + 1);
  localparam int ADDR_W = $clog2(MAX_DURATIONS);
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);
  localparam int MULT_W = TIME_BITS + 3;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DURATIONS);
  localparam logic [RES_W-1:0] RES_MAX = RES_W'(MAX_RESULTS);

  localparam logic [6:0] CHAR_SPACE  = 7'd32;
  localparam logic [6:0] CHAR_NONE   = 7'd0;
  localparam logic [6:0] CHAR_LETTER = 7'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_EVAL,
    ST_SPACE,
    ST_LAST,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [6:0] character;
    logic       unknown;
  } result_t;

  // Symbol count and code of each letter, dot 0, dash 1, first symbol in the MSB.
  localparam logic [2:0] LETTER_LEN [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [3:0] LETTER_CODE [26] = '{
    4'h1, 4'h8, 4'hA, 4'h4, 4'h0, 4'h2, 4'h6, 4'h0, 4'h0, 4'h7, 4'h5, 4'h4, 4'h3,
    4'h2, 4'h7, 4'h6, 4'hD, 4'h2, 4'h0, 4'h1, 4'h1, 4'h1, 4'h3, 4'h9, 4'hB, 4'hC
  };

  function automatic result_t letter_lookup(logic [3:0] bits, logic [2:0] count);
    result_t r;
    r.character = CHAR_NONE;
    r.unknown   = 1'b1;
    for (int k = 0; k < 26; k++) begin
      if (LETTER_LEN[k] == count && LETTER_CODE[k] == bits) begin
        r.character = CHAR_LETTER + 7'(k);
        r.unknown   = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

// ===== src/mtd_ram.sv =====
`timescale 1ns / 1ps

module mtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/morse_timing_decoder_unit.sv =====
`timescale 1ns / 1ps

// Morse timing decoder.
// Slave stream: one transfer per key edge. s_tdata carries the edge time in
// milliseconds, s_tuser flags the final edge of a message. Each edge but the
// first adds a duration to the duration RAM at the fill count while it has room.
// Master stream: one transfer per decoded character (a-z, space, or 0 with the
// unknown flag); m_tlast marks the last character of the message.
// After the final edge the block stops taking edges and walks the RAM: each
// stored duration is read from the RAM (ST_READ), then compared against the
// multiples of the shortest duration (ST_EVAL); a word gap adds ST_SPACE,
// and ST_SETUP, ST_LAST and ST_FLUSH frame the walk. Each character passes
// through a one-deep pending slot so the last one can carry tlast; the first
// character of a message leaves after the second one is produced, or at flush.
// A stalled receiver holds the walk: a character is produced only when the
// output register is empty. Edges of the next message are taken as soon as
// the flush has placed the last character, even while it still waits.
// Reset clears the fill count, the shortest duration (to all ones), the
// symbol shift register and both output slots; RAM contents are not cleared.

module morse_timing_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [26:0] timestamp_ms, [31:27] zero
  input  logic        s_tuser,   // [0] final_edge
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] character, [7] zero
  output logic        m_tuser,   // [0] unknown
  output logic        m_tlast    // end_of_text
);

  localparam int TB = mtd_pkg::TIME_BITS;
  localparam int CW = mtd_pkg::CNT_W;
  localparam int MW = mtd_pkg::MULT_W;

  mtd_pkg::state_t state, state_next;

  // Edge collection
  logic [TB-1:0] prev_time;
  logic          edge_seen;
  logic [CW-1:0] dur_count;
  logic [TB-1:0] shortest;

  // Walk
  logic [CW-1:0] idx;
  logic [MW-1:0] m1, m2, m3, m4, m7, m8;
  logic [3:0]    sym_bits;
  logic [2:0]    sym_count;
  logic [mtd_pkg::RES_W-1:0] res_count;

  // Pending and output slots
  logic              pend_valid;
  mtd_pkg::result_t  pend;
  logic              out_valid;
  mtd_pkg::result_t  out_res;
  logic              out_last;

  // RAM
  logic          wr_en;
  logic [TB-1:0] dur_new;
  logic [TB-1:0] rd_data;

  // Control from the output decoder
  logic             load;
  logic             out_free;
  logic             emit_en;
  mtd_pkg::result_t emit_res;
  logic             clear_sym;
  logic             push;
  logic             push_dash;
  logic             adv_idx;
  logic             flush_go;
  logic             is_one, is_three, is_seven;
  logic [MW-1:0]    d_ext;
  logic [CW-1:0]    idx_inc;
  logic             msg_empty;

  assign load     = s_tvalid && s_tready;
  assign out_free = !out_valid;
  assign dur_new  = s_tdata[TB-1:0] - prev_time;
  assign wr_en    = load && edge_seen && (dur_count < mtd_pkg::CNT_MAX);
  assign d_ext    = MW'(rd_data);
  assign idx_inc  = idx + 1'b1;
  assign msg_empty = (dur_count == '0) || (shortest == '0);

  // Quotient tests: duration in [k*p, (k+1)*p)
  assign is_one   = (d_ext >= m1) && (d_ext < m2);
  assign is_three = (d_ext >= m3) && (d_ext < m4);
  assign is_seven = (d_ext >= m7) && (d_ext < m8);

  mtd_ram #(
    .WIDTH(TB),
    .DEPTH(mtd_pkg::MAX_DURATIONS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(dur_count[mtd_pkg::ADDR_W-1:0]),
    .wr_data(dur_new),
    .rd_addr(idx[mtd_pkg::ADDR_W-1:0]),
    .rd_data(rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mtd_pkg::ST_IDLE: begin
        if (load && s_tuser) state_next = mtd_pkg::ST_SETUP;
      end
      mtd_pkg::ST_SETUP: begin
        if (msg_empty) begin
          if (out_free) state_next = mtd_pkg::ST_FLUSH;
        end else begin
          state_next = mtd_pkg::ST_READ;
        end
      end
      mtd_pkg::ST_READ: begin
        state_next = mtd_pkg::ST_EVAL;
      end
      mtd_pkg::ST_EVAL: begin
        if (out_free) begin
          if (idx[0] && is_seven) state_next = mtd_pkg::ST_SPACE;
          else if (idx_inc >= dur_count) state_next = mtd_pkg::ST_LAST;
          else state_next = mtd_pkg::ST_READ;
        end
      end
      mtd_pkg::ST_SPACE: begin
        if (out_free) begin
          state_next = (idx >= dur_count) ? mtd_pkg::ST_LAST : mtd_pkg::ST_READ;
        end
      end
      mtd_pkg::ST_LAST: begin
        if (out_free) state_next = mtd_pkg::ST_FLUSH;
      end
      mtd_pkg::ST_FLUSH: begin
        if (out_free) state_next = mtd_pkg::ST_IDLE;
      end
      default: state_next = mtd_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready  = 1'b0;
    emit_en   = 1'b0;
    emit_res  = mtd_pkg::letter_lookup(sym_bits, sym_count);
    clear_sym = 1'b0;
    push      = 1'b0;
    push_dash = 1'b0;
    adv_idx   = 1'b0;
    flush_go  = 1'b0;
    unique case (state)
      mtd_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      mtd_pkg::ST_SETUP: begin
        if (msg_empty && out_free) begin
          emit_en            = 1'b1;
          emit_res.character = mtd_pkg::CHAR_NONE;
          emit_res.unknown   = 1'b1;
        end
      end
      mtd_pkg::ST_READ: begin
      end
      mtd_pkg::ST_EVAL: begin
        if (out_free) begin
          adv_idx = 1'b1;
          if (!idx[0]) begin
            push      = is_one || is_three;
            push_dash = is_three;
          end else if (is_three || is_seven) begin
            emit_en   = 1'b1;
            clear_sym = 1'b1;
          end
        end
      end
      mtd_pkg::ST_SPACE: begin
        if (out_free) begin
          emit_en            = 1'b1;
          emit_res.character = mtd_pkg::CHAR_SPACE;
          emit_res.unknown   = 1'b0;
        end
      end
      mtd_pkg::ST_LAST: begin
        if (out_free) begin
          emit_en   = 1'b1;
          clear_sym = 1'b1;
        end
      end
      mtd_pkg::ST_FLUSH: begin
        flush_go = out_free;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and message bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mtd_pkg::ST_IDLE;
      prev_time  <= '0;
      edge_seen  <= 1'b0;
      dur_count  <= '0;
      shortest   <= '1;
      idx        <= '0;
      sym_bits   <= '0;
      sym_count  <= '0;
      res_count  <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      // Take an edge: store its duration and track the shortest one
      if (load) begin
        prev_time <= s_tdata[TB-1:0];
        edge_seen <= 1'b1;
      end
      if (wr_en) begin
        dur_count <= dur_count + 1'b1;
        if (dur_new < shortest) shortest <= dur_new;
      end

      // Build the period multiples for the walk
      if (state == mtd_pkg::ST_SETUP) begin
        idx <= '0;
        m1  <= MW'(shortest);
        m2  <= MW'(shortest) << 1;
        m3  <= MW'(shortest) + (MW'(shortest) << 1);
        m4  <= MW'(shortest) << 2;
        m7  <= (MW'(shortest) << 3) - MW'(shortest);
        m8  <= MW'(shortest) << 3;
      end

      if (adv_idx) idx <= idx_inc;

      // Shift in a dot or a dash, stop counting at five symbols
      if (push && (sym_count < 3'd5)) begin
        sym_bits  <= {sym_bits[2:0], push_dash};
        sym_count <= sym_count + 3'd1;
      end
      if (clear_sym) begin
        sym_bits  <= '0;
        sym_count <= '0;
      end

      // Drain the output register
      if (m_tvalid && m_tready) out_valid <= 1'b0;

      // Advance pending into the output slot, drop past the result limit
      if (emit_en && (res_count < mtd_pkg::RES_MAX)) begin
        res_count  <= res_count + 1'b1;
        pend_valid <= 1'b1;
        if (pend_valid) out_valid <= 1'b1;
      end

      // Release the last character and clear for the next message
      if (flush_go) begin
        if (pend_valid) out_valid <= 1'b1;
        pend_valid <= 1'b0;
        res_count  <= '0;
        prev_time  <= '0;
        edge_seen  <= 1'b0;
        dur_count  <= '0;
        shortest   <= '1;
        sym_bits   <= '0;
        sym_count  <= '0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit_en && (res_count < mtd_pkg::RES_MAX)) begin
      pend <= emit_res;
      if (pend_valid) begin
        out_res  <= pend;
        out_last <= 1'b0;
      end
    end
    if (flush_go && pend_valid) begin
      out_res  <= pend;
      out_last <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res.character};
  assign m_tuser  = out_res.unknown;
  assign m_tlast  = out_last;

endmodule

// ===== src/mtd_checker.sv =====
`timescale 1ns / 1ps

module mtd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
    else $error("result changed while stalled");

  // Stop taking edges once the final one is in
  a_final_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> !s_tready)
    else $error("edge taken during decode");

  // An unknown pattern carries no character
  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 8'd0))
    else $error("unknown result with nonzero character");

endmodule

bind morse_timing_decoder_unit mtd_checker u_mtd_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

// ===== tb/morse_timing_decoder_checker.sv =====
`timescale 1ns / 1ps

module morse_timing_decoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [26:0] timestamp_ms, [31:27] zero
  input  logic        s_tuser,   // [0] final_edge
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [6:0] character, [7] zero
  input  logic        m_tuser,   // [0] unknown
  input  logic        m_tlast,   // end_of_text
  output int          errors,
  output int          pending
);

  import mtd_pkg::*;

  typedef struct packed {
    logic [6:0] character;
    logic       unknown;
    logic       last;
  } decoded_char_t;

  logic [TIME_BITS-1:0] edge_gap [MAX_DURATIONS];
  logic [TIME_BITS-1:0] prev_edge;
  logic [TIME_BITS-1:0] unit_len;
  int                   gap_fill;
  bit                   edge_valid;
  string                letter_marks;

  decoded_char_t        text_q [$];
  decoded_char_t        msg_buf [MAX_RESULTS];
  int                   msg_len;

  function automatic string morse_code(int k);
    case (k)
      0:  return ".-";
      1:  return "-...";
      2:  return "-.-.";
      3:  return "-..";
      4:  return ".";
      5:  return "..-.";
      6:  return "--.";
      7:  return "....";
      8:  return "..";
      9:  return ".---";
      10: return "-.-";
      11: return ".-..";
      12: return "--";
      13: return "-.";
      14: return "---";
      15: return ".--.";
      16: return "--.-";
      17: return ".-.";
      18: return "...";
      19: return "-";
      20: return "..-";
      21: return "...-";
      22: return ".--";
      23: return "-..-";
      24: return "-.--";
      25: return "--..";
      default: return "";
    endcase
  endfunction

  task automatic put_char(logic [6:0] ch, logic unk);
    if (msg_len < MAX_RESULTS) begin
      msg_buf[msg_len] = '{character: ch, unknown: unk, last: 1'b0};
      msg_len++;
    end
  endtask

  // Letters longer than four symbols stop growing at five and match nothing.
  task automatic add_mark(string mark);
    if (letter_marks.len() < 5) begin
      letter_marks = {letter_marks, mark};
    end
  endtask

  task automatic close_letter();
    int         k;
    logic [6:0] ch;
    logic       unk;
    ch  = CHAR_NONE;
    unk = 1'b1;
    for (k = 0; k < 26; k++) begin
      if (unk && morse_code(k) == letter_marks) begin
        ch  = CHAR_LETTER + k[6:0];
        unk = 1'b0;
      end
    end
    put_char(ch, unk);
    letter_marks = "";
  endtask

  task automatic clear_message();
    prev_edge    = '0;
    gap_fill     = 0;
    unit_len     = '1;
    letter_marks = "";
    edge_valid   = 1'b0;
  endtask

  task automatic take_edge(logic [TIME_BITS-1:0] t, logic fin);
    logic [TIME_BITS-1:0] d;
    logic [TIME_BITS-1:0] q;
    int                   i;
    if (edge_valid) begin
      d = t - prev_edge;
      if (gap_fill < MAX_DURATIONS) begin
        edge_gap[gap_fill] = d;
        gap_fill++;
        if (d < unit_len) unit_len = d;
      end
    end
    prev_edge  = t;
    edge_valid = 1'b1;
    if (fin) begin
      msg_len = 0;
      if (gap_fill == 0 || unit_len == 0) begin
        put_char(CHAR_NONE, 1'b1);
      end else begin
        letter_marks = "";
        for (i = 0; i < gap_fill; i++) begin
          q = edge_gap[i] / unit_len;
          if (!i[0]) begin
            if (q == 1) add_mark(".");
            else if (q == 3) add_mark("-");
          end else begin
            if (q == 3) begin
              close_letter();
            end else if (q == 7) begin
              close_letter();
              put_char(CHAR_SPACE, 1'b0);
            end
          end
        end
        close_letter();
      end
      msg_buf[msg_len-1].last = 1'b1;
      for (i = 0; i < msg_len; i++) text_q.insert(text_q.size(), msg_buf[i]);
      clear_message();
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin : watch
    decoded_char_t want;
    if (rst) begin
      clear_message();
      text_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (text_q.size() == 0) begin
          errors++;
          $error("character: expected none, actual %0d (unknown %0b, last %0b)",
                 m_tdata[6:0], m_tuser, m_tlast);
        end else begin
          want = text_q.pop_front();
          if (m_tdata !== {1'b0, want.character}) begin
            errors++;
            $error("character: expected %0d, actual %0d", want.character, m_tdata);
          end
          if (m_tuser !== want.unknown) begin
            errors++;
            $error("unknown: expected %0b, actual %0b", want.unknown, m_tuser);
          end
          if (m_tlast !== want.last) begin
            errors++;
            $error("end_of_text: expected %0b, actual %0b", want.last, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready) take_edge(s_tdata[TIME_BITS-1:0], s_tuser);
    end
    pending = text_q.size();
  end

endmodule

// ===== tb/tb_morse_timing_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_morse_timing_decoder_unit;

  import mtd_pkg::*;

  // Stop the random phase after this many edge transfers.
  localparam int RAND_EDGES  = 300;
  // Latest timestamp within one day.
  localparam int T_MAX       = 86399999;
  // Cycles with no transfer on either side before the run is declared hung.
  localparam int WATCHDOG    = 20000;
  // One long receiver hold-off, started after this many characters.
  localparam int HOLD_AFTER  = 40;
  localparam int HOLD_CYCLES = 1500;
  // Quiet time after the last expected character: covers a full 64-entry walk.
  localparam int DRAIN       = 200;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [26:0] timestamp_ms, [31:27] zero
  logic        s_tuser;   // [0] final_edge
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [6:0] character, [7] zero
  logic        m_tuser;   // [0] unknown
  logic        m_tlast;   // end_of_text

  int errors;
  int pending;

  // Durations of the message being built; a negative entry steps time back.
  int gap_q [$];
  int edges_sent;
  bit src_calm;
  bit snk_calm;
  int chars_taken;
  bit hold_done;
  int stall_left;
  int idle_cycles;

  morse_timing_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  morse_timing_decoder_checker u_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length: mostly none or a few cycles, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Unit period: often the smallest, mostly moderate, sometimes very long.
  function automatic int pick_unit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 1;
    if (r < 85) return $urandom_range(2, 400);
    return $urandom_range(100000, 400000);
  endfunction

  // Offer one edge and hold it until the transfer happens. Valid stays high
  // afterwards so back-to-back edges need no extra assignment in one step.
  task automatic send_edge(logic [TIME_BITS-1:0] t, logic fin);
    int g;
    g = src_calm ? 0 : idle_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(32-TIME_BITS){1'b0}}, t};
    s_tuser  <= fin;
    do @(posedge clk); while (!s_tready);
    edges_sent++;
  endtask

  // Send the first edge at t0, then one edge per queued duration; flag the last.
  task automatic send_msg(int t0);
    logic [TIME_BITS-1:0] t;
    int                   i;
    t = TIME_BITS'(t0);
    if (gap_q.size() == 0) begin
      send_edge(t, 1'b1);
    end else begin
      send_edge(t, 1'b0);
      for (i = 0; i < gap_q.size(); i++) begin
        t = t + TIME_BITS'(gap_q[i]);
        send_edge(t, i == gap_q.size() - 1);
      end
    end
    gap_q.delete();
  endtask

  // Place the message at a random start that keeps every edge within the day.
  task automatic send_anywhere();
    int ahead;
    int back;
    int i;
    ahead = 0;
    back  = 0;
    for (i = 0; i < gap_q.size(); i++) begin
      if (gap_q[i] >= 0) ahead += gap_q[i];
      else back -= gap_q[i];
    end
    send_msg($urandom_range(back, T_MAX - ahead));
  endtask

  // Append one duration to the message being built.
  task automatic add_gap(int d);
    gap_q.insert(gap_q.size(), d);
  endtask

  // Queue one letter: marks of one or three units with one-unit gaps between.
  task automatic push_letter(int nsym, int p);
    int s;
    for (s = 0; s < nsym; s++) begin
      if (s > 0) add_gap(p);
      add_gap($urandom_range(0, 1) ? 3 * p : p);
    end
  endtask

  // Queue one or two words of random letters, now and then a five-symbol one.
  task automatic push_text(int p);
    int w;
    int l;
    int nw;
    int nl;
    nw = $urandom_range(1, 2);
    for (w = 0; w < nw; w++) begin
      if (w > 0) add_gap(7 * p);
      nl = $urandom_range(1, 3);
      for (l = 0; l < nl; l++) begin
        if (l > 0) add_gap(3 * p);
        push_letter(($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4), p);
      end
    end
  endtask

  task automatic random_msg(int idx);
    int p;
    int n;
    int i;
    int k;
    int target;
    src_calm = ($urandom_range(0, 3) == 0);
    if (idx == 2) begin
      // Dot, word gap, repeated: fills every result slot, final letter dropped.
      p = $urandom_range(1, 50);
      repeat (32) begin
        add_gap(p);
        add_gap(7 * p);
      end
    end else if (idx == 5) begin
      // Overrun the duration store, then add short durations that must be dropped.
      p = $urandom_range(2, 100);
      target = $urandom_range(64, 72);
      while (gap_q.size() < target) begin
        if (gap_q.size() > 0) add_gap(3 * p);
        push_letter($urandom_range(1, 4), p);
      end
      add_gap(1);
      add_gap(1);
    end else begin
      k = $urandom_range(0, 99);
      if (k < 70) begin
        push_text(pick_unit());
      end else if (k < 85) begin
        // Noise: near multiples of a period mixed with arbitrary durations.
        p = $urandom_range(1, 200);
        n = $urandom_range(1, 20);
        for (i = 0; i < n; i++) begin
          case ($urandom_range(0, 5))
            0: add_gap($urandom_range(0, 3000));
            1: add_gap(p);
            2: add_gap(2 * p + $urandom_range(0, p / 2));
            3: add_gap(3 * p + $urandom_range(0, p / 2));
            4: add_gap(7 * p + $urandom_range(0, p / 2));
            default: add_gap(4 * p);
          endcase
        end
      end else begin
        // Broken: corrupt one duration of a well-formed message, or add a word gap.
        p = $urandom_range(1, 300);
        push_text(p);
        i = $urandom_range(0, gap_q.size() - 1);
        case ($urandom_range(0, 3))
          0: gap_q[i] = $urandom_range(0, 5000);
          1: gap_q[i] = 0;
          2: gap_q[i] = -$urandom_range(1, 5000);
          default: add_gap(7 * p);
        endcase
      end
    end
    send_anywhere();
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    int base;
    int idx;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    rst      <= 1'b1;
    edges_sent = 0;
    src_calm   = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Lone final edge: no duration at all.
    send_msg(0);

    // Start and final edge both at the last millisecond of the day: zero period.
    add_gap(0);
    send_msg(T_MAX);

    // One-unit period: dot, word gap, dash.
    add_gap(1);
    add_gap(7);
    add_gap(3);
    send_msg(0);

    // Dot, letter gap, then time steps back: the wrapped mark is ignored,
    // a one-unit trailing gap is ignored, and the empty final letter is unknown.
    add_gap(10);
    add_gap(30);
    add_gap(-540);
    add_gap(10);
    send_msg(1000);

    // Five dots saturate the letter and a letter gap closes it, then an ignored
    // two-unit mark and four-unit gap before a closing dot.
    add_gap(5);
    repeat (4) begin
      add_gap(5);
      add_gap(5);
    end
    add_gap(15);
    add_gap(10);
    add_gap(20);
    add_gap(5);
    send_msg(T_MAX - 200);

    // Random messages until enough edges have gone in.
    base = edges_sent;
    idx  = 0;
    while (edges_sent - base < RAND_EDGES) begin
      random_msg(idx);
      idx++;
    end
    s_tvalid <= 1'b0;

    // Drain: let the last final edge reach the checker, wait for every
    // predicted character, then watch for strays.
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("morse_timing_decoder_unit verification clean");
    end else begin
      $display("morse_timing_decoder_unit verification failed");
    end
    $finish;
  end

  // Receiver: random stalls, calm stretches, and one long hold-off that
  // backs the decoder up until it stops taking edges.
  initial begin : receiver
    m_tready <= 1'b0;
    chars_taken = 0;
    hold_done   = 1'b0;
    stall_left  = 0;
    snk_calm    = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) chars_taken++;
      if ($urandom_range(0, 199) == 0) snk_calm = !snk_calm;
      if (!hold_done && chars_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        stall_left = snk_calm ? 0 : idle_len();
      end
    end
  end

  // Watchdog: count cycles without any transfer on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("morse_timing_decoder_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
src/mtd_pkg.sv
src/mtd_ram.sv
src/morse_timing_decoder_unit.sv
src/mtd_checker.sv
tb/morse_timing_decoder_checker.sv
tb/tb_morse_timing_decoder_unit.sv
